[hdl/llt_pkg.sv]
// ============================================================================
// Line lexer token classifier - shared types and constants
// Record kinds, token categories, error codes and the reserved word table.
// ============================================================================
package llt_pkg;

    localparam int NWORDS = 9;

    typedef enum logic [1:0] {
        PEND_NONE = 2'd0,
        PEND_WORD = 2'd1,
        PEND_NUM  = 2'd2,
        PEND_OP   = 2'd3
    } pend_t;

    localparam logic [1:0] KIND_TOKEN = 2'd0;
    localparam logic [1:0] KIND_LINE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [3:0] CAT_KEYWORD = 4'd0;
    localparam logic [3:0] CAT_IDENT   = 4'd1;
    localparam logic [3:0] CAT_STRING  = 4'd2;
    localparam logic [3:0] CAT_NUMBER  = 4'd3;
    localparam logic [3:0] CAT_ASSIGN  = 4'd4;
    localparam logic [3:0] CAT_ARITH   = 4'd5;
    localparam logic [3:0] CAT_LOGICAL = 4'd6;
    localparam logic [3:0] CAT_REL     = 4'd7;
    localparam logic [3:0] CAT_LPAREN  = 4'd8;
    localparam logic [3:0] CAT_RPAREN  = 4'd9;
    localparam logic [3:0] CAT_COLON   = 4'd10;
    localparam logic [3:0] CAT_COMMA   = 4'd11;
    localparam logic [3:0] CAT_COMMENT = 4'd12;
    localparam logic [3:0] CAT_INDENT  = 4'd13;
    localparam logic [3:0] CAT_UNKNOWN = 4'd14;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_PAREN   = 3'd1;
    localparam logic [2:0] ERR_QUOTE   = 3'd2;
    localparam logic [2:0] ERR_UNTERM  = 3'd3;
    localparam logic [2:0] ERR_TOOLONG = 3'd4;

    localparam logic [1:0] QUOTE_NONE   = 2'd0;
    localparam logic [1:0] QUOTE_DOUBLE = 2'd1;
    localparam logic [1:0] QUOTE_SINGLE = 2'd2;

    localparam logic [8:0] MASK_ALL = 9'h1FF;

    typedef struct packed {
        logic [1:0] record_kind;
        logic [3:0] category;
        logic [3:0] word_index;
        logic [7:0] first_char;
        logic [7:0] start_column;
        logic [8:0] token_length;
        logic [15:0] line_number;
        logic [2:0] error_code;
    } rec_t;

    typedef struct packed {
        logic [1:0] count;
        rec_t       r0;
        rec_t       r1;
        rec_t       r2;
    } recset_t;

    // Reserved word lengths
    function automatic logic [2:0] word_len(input int k);
        logic [2:0] l;
        case (k)
            0: l = 3'd5;
            1: l = 3'd2;
            2: l = 3'd4;
            3: l = 3'd4;
            4: l = 3'd3;
            5: l = 3'd5;
            6: l = 3'd3;
            7: l = 3'd2;
            default: l = 3'd3;
        endcase
        return l;
    endfunction

    // Reserved word character k at position p (zero past end)
    function automatic logic [7:0] word_char(input int k, input logic [2:0] p);
        logic [39:0] s;
        case (k)
            0: s = "tnirp";
            1: s = {24'd0, "fi"};
            2: s = {8'd0, "file"};
            3: s = {8'd0, "esle"};
            4: s = {16'd0, "rof"};
            5: s = "elihw";
            6: s = {16'd0, "dna"};
            7: s = {24'd0, "ro"};
            default: s = {16'd0, "ton"};
        endcase
        return (p < 3'd5) ? s[{p, 3'b000} +: 8] : 8'd0;
    endfunction

endpackage

[hdl/llt_core.sv]
// ============================================================================
// Line lexer core
// Holds lexer state and classifies one accepted item into up to three records.
// ============================================================================
module llt_core #(
    parameter int MAX_LINE = 256,
    parameter int CW = $clog2(MAX_LINE + 1)
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step,
    input  logic [7:0]      char_code,
    input  logic            line_end,
    output llt_pkg::recset_t recs
);
    import llt_pkg::*;

    pend_t       pend_reg, pend_next;
    logic [7:0]  pstart_reg, pstart_next;
    logic [8:0]  plen_reg, plen_next;
    logic [7:0]  pfirst_reg, pfirst_next;
    logic [8:0]  mask_reg, mask_next;
    logic [1:0]  quote_reg, quote_next;
    logic        comment_reg, comment_next;
    logic [CW-1:0] col_reg, col_next;
    logic [15:0] line_reg, line_next;
    logic        oseen_reg, oseen_next;
    logic        ounc_reg, ounc_next;
    logic        halt_reg, halt_next;

    logic [1:0]  n;
    rec_t        r [3];
    rec_t        tmp;
    logic [7:0]  c;
    logic [7:0]  col8;
    logic [8:0]  colw;
    logic        is_alpha, is_digit, is_space;
    logic [8:0]  m;
    logic [3:0]  wcat, widx;
    logic        wfound;
    logic [7:0]  mine, other;

    // Update state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= PEND_NONE; pstart_reg <= '0; plen_reg <= '0;
            pfirst_reg <= '0; mask_reg <= MASK_ALL; quote_reg <= QUOTE_NONE;
            comment_reg <= 1'b0; col_reg <= '0; line_reg <= '0;
            oseen_reg <= 1'b0; ounc_reg <= 1'b0; halt_reg <= 1'b0;
        end else if (step) begin
            pend_reg <= pend_next; pstart_reg <= pstart_next; plen_reg <= plen_next;
            pfirst_reg <= pfirst_next; mask_reg <= mask_next; quote_reg <= quote_next;
            comment_reg <= comment_next; col_reg <= col_next; line_reg <= line_next;
            oseen_reg <= oseen_next; ounc_reg <= ounc_next; halt_reg <= halt_next;
        end
    end

    // Classify the item and compute next state
    always_comb begin
        pend_next = pend_reg; pstart_next = pstart_reg; plen_next = plen_reg;
        pfirst_next = pfirst_reg; mask_next = mask_reg; quote_next = quote_reg;
        comment_next = comment_reg; col_next = col_reg; line_next = line_reg;
        oseen_next = oseen_reg; ounc_next = ounc_reg; halt_next = halt_reg;
        n = 2'd0;
        tmp = '0;
        tmp.line_number = line_reg;
        r[0] = tmp; r[1] = tmp; r[2] = tmp;
        c = char_code;
        colw = 9'(col_reg);
        col8 = colw[7:0];
        is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        is_digit = (c >= "0" && c <= "9");
        is_space = (c == " ") || (c >= 8'd9 && c <= 8'd13);
        m = '0; wcat = CAT_IDENT; widx = '0; wfound = 1'b0;
        mine = (quote_reg == QUOTE_DOUBLE) ? "\"" : "'";
        other = (quote_reg == QUOTE_DOUBLE) ? "'" : "\"";

        // Word lookup over the pending mask
        for (int k = NWORDS - 1; k >= 0; k--) begin
            if (mask_reg[k] && plen_reg == 9'(word_len(k))) begin
                wfound = 1'b1;
                widx = 4'(k);
                wcat = (k < 6) ? CAT_KEYWORD : CAT_LOGICAL;
            end
        end
        // Mask for extending the pending word with c
        for (int k = 0; k < NWORDS; k++) begin
            m[k] = mask_reg[k] && (plen_reg < 9'(word_len(k))) &&
                   (word_char(k, plen_reg[2:0]) == c);
        end

        if (!halt_reg) begin
            if (line_end) begin
                if (quote_reg != QUOTE_NONE || ounc_reg) begin
                    r[0].record_kind = KIND_ERROR;
                    r[0].start_column = col8;
                    r[0].error_code = (quote_reg != QUOTE_NONE) ? ERR_UNTERM : ERR_PAREN;
                    n = 2'd1; halt_next = 1'b1;
                end else begin
                    // Close the pending token
                    if (pend_reg != PEND_NONE) begin
                        r[n].first_char = pfirst_reg;
                        r[n].start_column = pstart_reg;
                        r[n].token_length = plen_reg;
                        case (pend_reg)
                            PEND_WORD: begin
                                r[n].category = wfound ? wcat : CAT_IDENT;
                                r[n].word_index = widx;
                            end
                            PEND_NUM: r[n].category = CAT_NUMBER;
                            default: begin
                                r[n].category = (pfirst_reg == "=") ? CAT_ASSIGN :
                                    (pfirst_reg == "!") ? CAT_UNKNOWN : CAT_REL;
                                r[n].token_length = 9'd1;
                            end
                        endcase
                        n = n + 2'd1;
                    end
                    if (comment_reg) begin
                        r[n].category = CAT_COMMENT;
                        r[n].first_char = "#";
                        r[n].token_length = colw;
                        n = n + 2'd1;
                    end
                    r[n].record_kind = KIND_LINE;
                    r[n].token_length = colw;
                    n = n + 2'd1;
                    line_next = line_reg + 16'd1;
                    col_next = '0; comment_next = 1'b0; oseen_next = 1'b0;
                    ounc_next = 1'b0; pstart_next = '0; mask_next = MASK_ALL;
                    pend_next = PEND_NONE; plen_next = '0;
                end
            end else if (32'(col_reg) >= MAX_LINE) begin
                r[0].record_kind = KIND_ERROR;
                r[0].start_column = col8;
                r[0].error_code = ERR_TOOLONG;
                n = 2'd1; halt_next = 1'b1;
            end else begin
                col_next = col_reg + CW'(1);
                if (c == ")") ounc_next = 1'b0;
                if (comment_reg) begin
                    if (c == "(") oseen_next = 1'b1;
                end else if (quote_reg != QUOTE_NONE) begin
                    if (c == "(") oseen_next = 1'b1;
                    plen_next = plen_reg + 9'd1;
                    if (c == mine) begin
                        r[0].category = CAT_STRING;
                        r[0].first_char = pfirst_reg;
                        r[0].start_column = pstart_reg;
                        r[0].token_length = plen_reg + 9'd1;
                        n = 2'd1;
                        quote_next = QUOTE_NONE; plen_next = '0;
                    end else if (c == other) begin
                        r[0].record_kind = KIND_ERROR;
                        r[0].start_column = col8;
                        r[0].error_code = ERR_QUOTE;
                        n = 2'd1; halt_next = 1'b1;
                    end
                end else if (pend_reg == PEND_WORD && is_alpha) begin
                    mask_next = m;
                    plen_next = plen_reg + 9'd1;
                end else if (pend_reg == PEND_NUM && (is_digit || c == ".")) begin
                    plen_next = plen_reg + 9'd1;
                end else if (pend_reg == PEND_OP && c == "=") begin
                    r[0].category = CAT_REL;
                    r[0].first_char = pfirst_reg;
                    r[0].start_column = pstart_reg;
                    r[0].token_length = 9'd2;
                    n = 2'd1;
                    pend_next = PEND_NONE; plen_next = '0;
                end else begin
                    // Close pending token, then start fresh
                    if (pend_reg != PEND_NONE) begin
                        r[0].first_char = pfirst_reg;
                        r[0].start_column = pstart_reg;
                        r[0].token_length = plen_reg;
                        case (pend_reg)
                            PEND_WORD: begin
                                r[0].category = wfound ? wcat : CAT_IDENT;
                                r[0].word_index = widx;
                            end
                            PEND_NUM: r[0].category = CAT_NUMBER;
                            default: begin
                                r[0].category = (pfirst_reg == "=") ? CAT_ASSIGN :
                                    (pfirst_reg == "!") ? CAT_UNKNOWN : CAT_REL;
                                r[0].token_length = 9'd1;
                            end
                        endcase
                        n = 2'd1;
                    end
                    pend_next = PEND_NONE; plen_next = '0;
                    r[n].first_char = c;
                    r[n].start_column = col8;
                    r[n].token_length = 9'd1;
                    if (col_reg == '0 && is_space) begin
                        r[n].category = CAT_INDENT;
                        n = n + 2'd1;
                    end else if (is_digit || is_alpha) begin
                        pend_next = is_digit ? PEND_NUM : PEND_WORD;
                        pfirst_next = c; pstart_next = col8; plen_next = 9'd1;
                        mask_next = is_digit ? MASK_ALL : MASK_ALL & {
                            word_char(8, 3'd0) == c, word_char(7, 3'd0) == c,
                            word_char(6, 3'd0) == c, word_char(5, 3'd0) == c,
                            word_char(4, 3'd0) == c, word_char(3, 3'd0) == c,
                            word_char(2, 3'd0) == c, word_char(1, 3'd0) == c,
                            word_char(0, 3'd0) == c};
                    end else if (c == "(") begin
                        r[n].category = CAT_LPAREN;
                        n = n + 2'd1;
                        ounc_next = 1'b1;
                        oseen_next = 1'b1;
                    end else if (c == ")") begin
                        if (!oseen_reg) begin
                            r[n] = tmp;
                            r[n].record_kind = KIND_ERROR;
                            r[n].start_column = col8;
                            r[n].error_code = ERR_PAREN;
                            halt_next = 1'b1;
                        end else begin
                            r[n].category = CAT_RPAREN;
                        end
                        n = n + 2'd1;
                    end else if (c == "\"" || c == "'") begin
                        quote_next = (c == "\"") ? QUOTE_DOUBLE : QUOTE_SINGLE;
                        pfirst_next = c; pstart_next = col8; plen_next = 9'd1;
                    end else if (c == "#") begin
                        comment_next = 1'b1;
                    end else if (c == "<" || c == ">" || c == "=" || c == "!") begin
                        pend_next = PEND_OP;
                        pfirst_next = c; pstart_next = col8; plen_next = 9'd1;
                        mask_next = MASK_ALL;
                    end else if (c == "+" || c == "-" || c == "*" || c == "/" ||
                                 c == "%") begin
                        r[n].category = CAT_ARITH;
                        n = n + 2'd1;
                    end else if (c == ":") begin
                        r[n].category = CAT_COLON;
                        n = n + 2'd1;
                    end else if (c == ",") begin
                        r[n].category = CAT_COMMA;
                        n = n + 2'd1;
                    end else if (!is_space) begin
                        r[n].category = CAT_UNKNOWN;
                        n = n + 2'd1;
                    end
                end
            end
        end
        recs.count = n;
        recs.r0 = r[0];
        recs.r1 = r[1];
        recs.r2 = r[2];
    end

`ifndef SYNTHESIS
    // Once halted, the block stays halted until reset
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halt_reg |=> halt_reg) else $error("halt cleared");
    // Halted block produces no records
    a_halt_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        halt_reg |-> recs.count == 2'd0) else $error("records while halted");
    // Column never exceeds the line limit
    a_col_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(col_reg) <= MAX_LINE) else $error("column overflow");
`endif

endmodule

[hdl/llt_outq.sv]
// ============================================================================
// Line lexer output serializer
// Holds up to three records of one item and sends them one per cycle while m_tready is high.
// ============================================================================
module llt_outq (
    input  logic             aclk,
    input  logic             aresetn,
    input  llt_pkg::recset_t in_recs,
    input  logic             in_load,
    output logic             can_load,
    output logic             m_tvalid,
    input  logic             m_tready,
    output llt_pkg::rec_t    m_rec,
    output logic             m_last
);
    import llt_pkg::*;

    rec_t       buf_reg [3];
    logic [1:0] cnt_reg, idx_reg;
    logic       fire;

    assign fire = m_tvalid && m_tready;
    assign m_tvalid = cnt_reg != 2'd0;
    assign m_rec = buf_reg[idx_reg];
    assign m_last = (idx_reg + 2'd1) == cnt_reg;
    // Accept when empty or the final record leaves this cycle
    assign can_load = !m_tvalid || (fire && m_last);

    // Control: record count and read index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end else if (in_load) begin
            cnt_reg <= in_recs.count;
            idx_reg <= '0;
        end else if (fire) begin
            if (m_last) begin
                cnt_reg <= '0;
                idx_reg <= '0;
            end else begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    // Payload capture
    always_ff @(posedge aclk) begin
        if (in_load) begin
            buf_reg[0] <= in_recs.r0;
            buf_reg[1] <= in_recs.r1;
            buf_reg[2] <= in_recs.r2;
        end
    end

`ifndef SYNTHESIS
    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> idx_reg < cnt_reg) else $error("index past count");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        in_load |-> can_load) else $error("load while busy");
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3 || idx_reg <= 2'd2) else $error("bad count");
`endif

endmodule

[hdl/line_lexer_token_classifier_top.sv]
// Latency: results of an item appear the cycle after it is accepted.
// Throughput: one item per cycle while m_tready is high and each item gives at most
// one result; an item giving more results holds input until they drain.
// Reset (aresetn low, synchronous) clears the lexer state, line and column
// counters and the halt flag, and empties the output stage.
// ============================================================================
// Line lexer token classifier - top level
// Streams characters in and classified token, line and error records out.
// ============================================================================
module line_lexer_token_classifier_top #(
    parameter int MAX_LINE = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tuser,   // [0] line_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // category, word_index, first_char, start_column,
                                   // token_length, line_number, error_code
                                   // (low to high), zero pad
    output logic [1:0]  m_tuser,   // [1:0] record_kind
    output logic        m_tlast
);
    import llt_pkg::*;

    recset_t recs;
    rec_t    orec;
    logic    step;
    logic    can_load;

    assign s_tready = can_load;
    assign step = s_tvalid && s_tready;

    llt_core #(.MAX_LINE(MAX_LINE)) u_core (
        .aclk(aclk), .aresetn(aresetn), .step(step),
        .char_code(s_tdata), .line_end(s_tuser), .recs(recs)
    );

    llt_outq u_outq (
        .aclk(aclk), .aresetn(aresetn), .in_recs(recs),
        .in_load(step && recs.count != 2'd0), .can_load(can_load),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_rec(orec), .m_last(m_tlast)
    );

    // Pack the record fields, first field lowest
    assign m_tdata = {4'd0, orec.error_code, orec.line_number, orec.token_length,
                      orec.start_column, orec.first_char, orec.word_index,
                      orec.category};
    assign m_tuser = orec.record_kind;

endmodule

[sim/tb_lexer_checker.sv]
`timescale 1ns / 100ps
// ============================================================================
// Lexer record checker
// Watches the character and record channels, runs its own model of the
// lexer on every accepted item and compares each record field by field.
// ============================================================================
module tb_lexer_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          outstanding,
    output int          record_count
);
    import llt_pkg::*;

    typedef struct {
        logic [1:0]  kind;
        logic [3:0]  cat;
        logic [3:0]  word;
        logic [7:0]  first;
        logic [7:0]  start;
        logic [8:0]  len;
        logic [15:0] line;
        logic [2:0]  err;
        logic        last;
    } lex_rec_t;

    localparam int LINE_LIMIT = 256;

    string word_names[NWORDS] = '{"print", "if", "elif", "else", "for", "while",
                                  "and", "or", "not"};

    lex_rec_t expected_recs[$];
    lex_rec_t step_recs[$];

    // lexer model state
    pend_t       held_kind;
    int          held_start;
    int          held_len;
    logic [7:0]  held_first;
    logic [8:0]  word_mask;
    logic [1:0]  quote_state;
    logic        in_comment;
    int          column;
    logic [15:0] line_no;
    logic        paren_seen;
    logic        paren_open;
    logic        stopped;

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_num(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic void put_rec(logic [1:0] kind, logic [3:0] cat, logic [3:0] word,
                                    logic [7:0] first, int start, int len, logic [2:0] err);
        lex_rec_t r;
        if (step_recs.size() >= 3) return;
        r.kind = kind; r.cat = cat; r.word = word; r.first = first;
        r.start = start[7:0]; r.len = len[8:0]; r.line = line_no; r.err = err;
        r.last = 1'b0;
        step_recs.insert(step_recs.size(), r);
    endfunction

    function automatic void flag_error(logic [2:0] code, int col);
        put_rec(KIND_ERROR, 4'd0, 4'd0, 8'd0, col, 0, code);
        stopped = 1'b1;
    endfunction

    // narrow the candidate reserved words by the next letter
    function automatic void narrow_words(logic [7:0] c);
        for (int k = 0; k < NWORDS; k++)
            if (held_len >= word_names[k].len() || word_names[k][held_len] != c)
                word_mask[k] = 1'b0;
    endfunction

    function automatic void flush_held();
        logic [3:0] cat;
        logic [3:0] idx;
        if (held_kind == PEND_WORD) begin
            cat = CAT_IDENT;
            idx = 4'd0;
            for (int k = 0; k < NWORDS; k++) begin
                if (word_mask[k] && held_len == word_names[k].len()) begin
                    cat = (k < 6) ? CAT_KEYWORD : CAT_LOGICAL;
                    idx = k[3:0];
                    break;
                end
            end
            put_rec(KIND_TOKEN, cat, idx, held_first, held_start, held_len, ERR_NONE);
        end else if (held_kind == PEND_NUM) begin
            put_rec(KIND_TOKEN, CAT_NUMBER, 4'd0, held_first, held_start, held_len, ERR_NONE);
        end else if (held_kind == PEND_OP) begin
            cat = (held_first == "=") ? CAT_ASSIGN :
                  (held_first == "!") ? CAT_UNKNOWN : CAT_REL;
            put_rec(KIND_TOKEN, cat, 4'd0, held_first, held_start, 1, ERR_NONE);
        end
        held_kind = PEND_NONE;
        held_len = 0;
    endfunction

    function automatic void hold_token(pend_t kind, logic [7:0] c, int col);
        held_kind = kind;
        held_first = c;
        held_start = col;
        held_len = 0;
        word_mask = MASK_ALL;
        if (kind == PEND_WORD) narrow_words(c);
        held_len = 1;
    endfunction

    // classify a character that begins something new
    function automatic void begin_token(logic [7:0] c, int col);
        if (col == 0 && is_blank(c))
            put_rec(KIND_TOKEN, CAT_INDENT, 4'd0, c, 0, 1, ERR_NONE);
        else if (is_num(c))
            hold_token(PEND_NUM, c, col);
        else if (is_letter(c))
            hold_token(PEND_WORD, c, col);
        else if (c == "(") begin
            put_rec(KIND_TOKEN, CAT_LPAREN, 4'd0, c, col, 1, ERR_NONE);
            paren_open = 1'b1;
        end else if (c == ")") begin
            if (!paren_seen) flag_error(ERR_PAREN, col);
            else put_rec(KIND_TOKEN, CAT_RPAREN, 4'd0, c, col, 1, ERR_NONE);
        end else if (c == "\"" || c == "'") begin
            quote_state = (c == "\"") ? QUOTE_DOUBLE : QUOTE_SINGLE;
            held_first = c;
            held_start = col;
            held_len = 1;
        end else if (c == "#")
            in_comment = 1'b1;
        else if (c == "<" || c == ">" || c == "=" || c == "!")
            hold_token(PEND_OP, c, col);
        else if (c == "+" || c == "-" || c == "*" || c == "/" || c == "%")
            put_rec(KIND_TOKEN, CAT_ARITH, 4'd0, c, col, 1, ERR_NONE);
        else if (c == ":")
            put_rec(KIND_TOKEN, CAT_COLON, 4'd0, c, col, 1, ERR_NONE);
        else if (c == ",")
            put_rec(KIND_TOKEN, CAT_COMMA, 4'd0, c, col, 1, ERR_NONE);
        else if (!is_blank(c))
            put_rec(KIND_TOKEN, CAT_UNKNOWN, 4'd0, c, col, 1, ERR_NONE);
    endfunction

    function automatic void close_line();
        if (quote_state != QUOTE_NONE) begin
            flag_error(ERR_UNTERM, column);
            return;
        end
        if (paren_open) begin
            flag_error(ERR_PAREN, column);
            return;
        end
        flush_held();
        if (in_comment) put_rec(KIND_TOKEN, CAT_COMMENT, 4'd0, "#", 0, column, ERR_NONE);
        put_rec(KIND_LINE, 4'd0, 4'd0, 8'd0, 0, column, ERR_NONE);
        line_no++;
        column = 0;
        in_comment = 1'b0;
        paren_seen = 1'b0;
        paren_open = 1'b0;
        held_start = 0;
        word_mask = MASK_ALL;
    endfunction

    function automatic void lex_char(logic [7:0] c);
        int col;
        logic [7:0] mine;
        logic [7:0] other;
        logic [3:0] cat;
        if (column >= LINE_LIMIT) begin
            flag_error(ERR_TOOLONG, column);
            return;
        end
        col = column;
        column++;
        if (c == ")") paren_open = 1'b0;
        if (in_comment) begin
            if (c == "(") paren_seen = 1'b1;
            return;
        end
        if (quote_state != QUOTE_NONE) begin
            mine  = (quote_state == QUOTE_DOUBLE) ? "\"" : "'";
            other = (quote_state == QUOTE_DOUBLE) ? "'" : "\"";
            if (c == "(") paren_seen = 1'b1;
            held_len++;
            if (c == mine) begin
                put_rec(KIND_TOKEN, CAT_STRING, 4'd0, held_first, held_start, held_len,
                        ERR_NONE);
                quote_state = QUOTE_NONE;
                held_len = 0;
            end else if (c == other)
                flag_error(ERR_QUOTE, col);
            return;
        end
        if (held_kind == PEND_WORD && is_letter(c)) begin
            narrow_words(c);
            held_len++;
            return;
        end
        if (held_kind == PEND_NUM && (is_num(c) || c == ".")) begin
            held_len++;
            return;
        end
        if (held_kind == PEND_OP && c == "=") begin
            cat = (held_first == "=" || held_first == "!" || held_first == "<" ||
                   held_first == ">") ? CAT_REL : CAT_UNKNOWN;
            put_rec(KIND_TOKEN, cat, 4'd0, held_first, held_start, 2, ERR_NONE);
            held_kind = PEND_NONE;
            held_len = 0;
            return;
        end
        flush_held();
        begin_token(c, col);
        if (c == "(") paren_seen = 1'b1;
    endfunction

    // predict on accepted characters, compare accepted records
    always @(posedge aclk) begin
        lex_rec_t e;
        lex_rec_t a;
        bit bad;
        if (!aresetn) begin
            held_kind = PEND_NONE; held_start = 0; held_len = 0; held_first = 8'd0;
            word_mask = MASK_ALL; quote_state = QUOTE_NONE; in_comment = 1'b0;
            column = 0; line_no = 16'd0; paren_seen = 1'b0; paren_open = 1'b0;
            stopped = 1'b0;
            expected_recs.delete();
            fail_count <= 0;
            record_count <= 0;
        end else begin
            if (s_tvalid && s_tready && !stopped) begin
                step_recs.delete();
                if (s_tuser) close_line();
                else lex_char(s_tdata);
                if (step_recs.size() > 0) step_recs[step_recs.size() - 1].last = 1'b1;
                foreach (step_recs[i]) expected_recs.insert(expected_recs.size(), step_recs[i]);
            end
            if (m_tvalid && m_tready) begin
                record_count <= record_count + 1;
                a.kind = m_tuser;         a.cat = m_tdata[3:0];    a.word = m_tdata[7:4];
                a.first = m_tdata[15:8];  a.start = m_tdata[23:16]; a.len = m_tdata[32:24];
                a.line = m_tdata[48:33];  a.err = m_tdata[51:49];  a.last = m_tlast;
                if (expected_recs.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: unexpected record kind=%0d cat=%0d first=%h",
                                 $realtime, a.kind, a.cat, a.first);
                    fail_count <= fail_count + 1;
                end else begin
                    e = expected_recs.pop_front();
                    bad = (a.kind != e.kind) || (a.cat != e.cat) || (a.word != e.word) ||
                          (a.first != e.first) || (a.start != e.start) ||
                          (a.len != e.len) || (a.line != e.line) || (a.err != e.err) ||
                          (a.last !== e.last);
                    if (bad) begin
                        if (fail_count < 10) begin
                            $display("%0t: record mismatch on line %0d", $realtime, e.line);
                            $display({"  exp kind=%0d cat=%0d word=%0d first=%h col=%0d",
                                      " len=%0d line=%0d err=%0d last=%0d"},
                                     e.kind, e.cat, e.word, e.first, e.start, e.len,
                                     e.line, e.err, e.last);
                            $display({"  got kind=%0d cat=%0d word=%0d first=%h col=%0d",
                                      " len=%0d line=%0d err=%0d last=%0d"},
                                     a.kind, a.cat, a.word, a.first, a.start, a.len,
                                     a.line, a.err, a.last);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
        outstanding <= expected_recs.size();
    end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// ============================================================================
// Line lexer token classifier testbench
// Feeds directed and random source lines with random gaps and back-pressure;
// the checker predicts every record and counts mismatches.
// ============================================================================
module tb_top;

    localparam int CYCLE_LIMIT = 800000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int fail_count;
    int outstanding;
    int record_count;
    int char_count;
    int line_count;
    int cycle_count = 0;
    bit no_gaps;

    string kw_list[9] = '{"print", "if", "elif", "else", "for", "while", "and", "or", "not"};

    line_lexer_token_classifier_top i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    tb_lexer_checker i_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .fail_count(fail_count), .outstanding(outstanding), .record_count(record_count)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // stop a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // record side: random stall before each item
    always begin
        int stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // push one item after a random gap
    task automatic send_item(logic [7:0] c, logic eol);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= eol ? 8'($urandom) : c;
        s_tuser  <= eol;
        do @(posedge aclk); while (!s_tready);
        if (eol) line_count++;
        else char_count++;
    endtask

    task automatic send_line(byte q[$]);
        foreach (q[i]) send_item(q[i], 1'b0);
        send_item(8'd0, 1'b1);
    endtask

    // append one byte to a line
    function automatic void put_byte(ref byte q[$], input byte c);
        q.insert(q.size(), c);
    endfunction

    function automatic void add_text(ref byte q[$], input string s);
        for (int i = 0; i < s.len(); i++) put_byte(q, s[i]);
    endfunction

    // any byte but quotes, parentheses and the comment mark
    function automatic byte plain_byte();
        byte c;
        do c = byte'($urandom); while (c == "\"" || c == "'" || c == "(" || c == ")" ||
                                       c == "#");
        return c;
    endfunction

    function automatic byte letter();
        int n;
        n = $urandom_range(0, 51);
        return (n < 26) ? byte'("a" + n) : byte'("A" + n - 26);
    endfunction

    // build one well-formed line from random pieces
    function automatic void random_line(ref byte q[$]);
        int pieces;
        byte qc;
        string ops;
        q.delete();
        if ($urandom_range(0, 2) == 0)
            put_byte(q, ($urandom_range(0, 1) != 0) ? byte'(" ") :
                        byte'($urandom_range(9, 13)));
        pieces = $urandom_range(0, 8);
        ops = "<>=!+-*/%:,";
        for (int p = 0; p < pieces && q.size() < 180; p++) begin
            case ($urandom_range(0, 7))
                0: add_text(q, kw_list[$urandom_range(0, 8)]);
                1: repeat ($urandom_range(1, 6)) put_byte(q, letter());
                2: begin
                    put_byte(q, byte'("0" + $urandom_range(0, 9)));
                    repeat ($urandom_range(0, 4))
                        put_byte(q, ($urandom_range(0, 3) == 0) ? byte'(".") :
                                    byte'("0" + $urandom_range(0, 9)));
                end
                3: begin
                    put_byte(q, ops[$urandom_range(0, ops.len() - 1)]);
                    if ($urandom_range(0, 1) != 0) put_byte(q, byte'("="));
                end
                4: begin
                    qc = ($urandom_range(0, 1) != 0) ? byte'("\"") : byte'("'");
                    put_byte(q, qc);
                    repeat ($urandom_range(0, 5)) put_byte(q, plain_byte());
                    put_byte(q, qc);
                end
                5: begin
                    put_byte(q, byte'("("));
                    repeat ($urandom_range(0, 3)) put_byte(q, letter());
                    put_byte(q, byte'(")"));
                end
                6: put_byte(q, plain_byte());
                default: put_byte(q, byte'($urandom_range(9, 13)));
            endcase
            if ($urandom_range(0, 9) < 7) put_byte(q, byte'(" "));
        end
        if ($urandom_range(0, 5) == 0) begin
            put_byte(q, byte'("#"));
            repeat ($urandom_range(0, 8)) put_byte(q, byte'($urandom));
        end
    endfunction

    initial begin
        byte q[$];
        int mode;
        s_tvalid = 1'b0;
        s_tdata  = 8'd0;
        s_tuser  = 1'b0;
        m_tready = 1'b0;
        aresetn  = 1'b0;
        char_count = 0;
        line_count = 0;
        no_gaps = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed lines: every keyword, operators, strings, comments, extremes
        q.delete(); add_text(q, "\tprint(a1,b) if elif else for while and or not x"); send_line(q);
        q.delete(); add_text(q, " y=3.14<=x>=2!=1==0<>! !x%/*-+:");
        put_byte(q, byte'(8'h00)); put_byte(q, byte'(8'hFF)); send_line(q);
        q.delete(); add_text(q, "s='a'\"b\"c fore ()#)'\"x"); send_line(q);
        q.delete(); send_line(q);

        // random lines; a run without gaps in the middle
        for (int n = 0; char_count + line_count < 250; n++) begin
            no_gaps = (n >= 5 && n < 10);
            random_line(q);
            send_line(q);
            // let the block drain completely once
            if (n == 3) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (outstanding != 0) @(posedge aclk);
            end
        end
        no_gaps = 1'b0;

        // longest legal line
        q.delete();
        for (int i = 0; i < 256; i++) put_byte(q, (i % 3 == 2) ? byte'(" ") : letter());
        send_line(q);

        // one error ends the lexing for good
        mode = $urandom_range(0, 4);
        q.delete();
        case (mode)
            0: add_text(q, "a)");
            1: add_text(q, "x=\"ab'");
            2: add_text(q, "f(x");
            3: add_text(q, "'open");
            default: repeat (257) put_byte(q, letter());
        endcase
        send_line(q);
        add_text(q, "ignored");
        send_line(q);
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Sent %0d characters over %0d line ends; %0d records checked.",
                 char_count, line_count, record_count);
        $display("Covered keywords, operators, strings, comments, indent, a full-length line");
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[files.f]
hdl/llt_pkg.sv
hdl/llt_core.sv
hdl/llt_outq.sv
hdl/line_lexer_token_classifier_top.sv
sim/tb_lexer_checker.sv
sim/tb_top.sv
